// ===== hdl/fpl2_pkg.sv =====
// ----------------------------------------------------------------------------
// fpl2_pkg: shared types and constants for the fixed-point log2 block
// Operand and result widths, multiplier limb geometry and the
// column-ordered partial-product schedule of the squaring unit.
// ----------------------------------------------------------------------------
package fpl2_pkg;

  // Operand: 64 integer bits over 128 fraction bits
  localparam int X_INT_W     = 64;
  localparam int X_FRAC_W    = 128;
  localparam int X_W         = X_INT_W + X_FRAC_W;
  localparam int WORD_W      = 64;

  // Result
  localparam int LOG_INT_W   = 8;
  localparam int LOG_FRAC_W  = 128;
  localparam int OUT_TDATA_W = 136;   // 8 + 64 + 64, already whole bytes
  localparam int OUT_TUSER_W = 1;

  // Leading-zero count range and its step count (128, 64, ... 1)
  localparam int LZ_W        = 8;
  localparam int NORM_STEPS  = 8;
  localparam int STEP_W      = 3;

  // Squaring unit: 4 limbs of 32 bits, 16 partial products
  localparam int LIMB_W      = 32;
  localparam int N_LIMBS     = 4;
  localparam int N_PAIRS     = 16;
  localparam int PAIR_W      = 4;
  localparam int PROD_W      = 2 * LIMB_W;
  localparam int ACC_W       = 68;    // one column of four products plus carry
  localparam int COL_W       = 3;
  localparam int FRAC_CNT_W  = 7;

  // One entry of the product-scanning schedule
  typedef struct packed {
    logic [1:0] ia;
    logic [1:0] ib;
    logic       col_end;   // last product of its column
  } pair_t;

  // Partial products ordered by column i+j, lowest column first
  function automatic pair_t pair_at(input logic [PAIR_W-1:0] k);
    pair_t p;
    unique case (k)
      4'd0:  p = '{ia: 2'd0, ib: 2'd0, col_end: 1'b1};
      4'd1:  p = '{ia: 2'd0, ib: 2'd1, col_end: 1'b0};
      4'd2:  p = '{ia: 2'd1, ib: 2'd0, col_end: 1'b1};
      4'd3:  p = '{ia: 2'd0, ib: 2'd2, col_end: 1'b0};
      4'd4:  p = '{ia: 2'd1, ib: 2'd1, col_end: 1'b0};
      4'd5:  p = '{ia: 2'd2, ib: 2'd0, col_end: 1'b1};
      4'd6:  p = '{ia: 2'd0, ib: 2'd3, col_end: 1'b0};
      4'd7:  p = '{ia: 2'd1, ib: 2'd2, col_end: 1'b0};
      4'd8:  p = '{ia: 2'd2, ib: 2'd1, col_end: 1'b0};
      4'd9:  p = '{ia: 2'd3, ib: 2'd0, col_end: 1'b1};
      4'd10: p = '{ia: 2'd1, ib: 2'd3, col_end: 1'b0};
      4'd11: p = '{ia: 2'd2, ib: 2'd2, col_end: 1'b0};
      4'd12: p = '{ia: 2'd3, ib: 2'd1, col_end: 1'b1};
      4'd13: p = '{ia: 2'd2, ib: 2'd3, col_end: 1'b0};
      4'd14: p = '{ia: 2'd3, ib: 2'd2, col_end: 1'b1};
      4'd15: p = '{ia: 2'd3, ib: 2'd3, col_end: 1'b1};
      default: p = '{ia: 2'd0, ib: 2'd0, col_end: 1'b0};
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/fpl2_norm.sv =====
// ----------------------------------------------------------------------------
// fpl2_norm: leading-zero normalizer
// Shifts a nonzero 192-bit operand left until its top bit is set, testing
// spans of 128, 64, ... 1 bits, one span per cycle. Reports the count and
// the 128 bits that follow the leading one.
// ----------------------------------------------------------------------------
module fpl2_norm (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [fpl2_pkg::X_W-1:0]       x,
  output logic                           done,
  output logic [fpl2_pkg::LZ_W-1:0]      lz,
  output logic [fpl2_pkg::X_FRAC_W-1:0]  frac
);
  import fpl2_pkg::*;

  logic [X_W-1:0]    w_r,    w_nxt;
  logic [LZ_W-1:0]   lz_r,   lz_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [LZ_W-1:0]   shamt;
  logic              top_zero;

  // Span tested this cycle and whether it is all zero
  assign shamt    = LZ_W'(X_FRAC_W) >> step_r;
  assign top_zero = ((w_r >> (LZ_W'(X_W) - shamt)) == '0);

  always_comb begin
    w_nxt    = w_r;
    lz_nxt   = lz_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      w_nxt    = x;
      lz_nxt   = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (top_zero) begin
        w_nxt  = w_r << shamt;
        lz_nxt = lz_r + shamt;
      end
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(NORM_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    w_r  <= w_nxt;
    lz_r <= lz_nxt;
  end

  assign done = done_r;
  assign lz   = lz_r;
  assign frac = w_r[X_W-2 -: X_FRAC_W];

endmodule

// ===== hdl/fpl2_sqr.sv =====
// ----------------------------------------------------------------------------
// fpl2_sqr: iterative squaring unit
// Forms the upper 128 bits of F*F for a 128-bit F with one 32x32
// multiplier, product-scanning by column: 16 products, one per cycle,
// into a column accumulator that retires one 32-bit limb per column.
// ----------------------------------------------------------------------------
module fpl2_sqr (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [fpl2_pkg::X_FRAC_W-1:0]  f,
  output logic                           done,
  output logic [fpl2_pkg::X_FRAC_W-1:0]  hi
);
  import fpl2_pkg::*;

  logic              run_r;
  logic [PAIR_W-1:0] iss_r;
  logic              pv_r;
  logic              pcol_r;
  logic              plast_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic [COL_W-1:0]  col_r;
  logic [LIMB_W-1:0] limb_r [3];
  logic              done_r;

  pair_t             pr;
  logic [LIMB_W-1:0] op_a, op_b;
  logic [ACC_W-1:0]  sum;

  // Operand limbs for the current schedule entry
  assign pr   = pair_at(iss_r);
  assign op_a = f[LIMB_W*pr.ia +: LIMB_W];
  assign op_b = f[LIMB_W*pr.ib +: LIMB_W];
  assign sum  = acc_r + ACC_W'(prod_r);

  // Issue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      iss_r  <= '0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      col_r  <= '0;
    end else begin
      done_r <= pv_r && plast_r;
      pv_r   <= run_r;
      if (start) begin
        run_r <= 1'b1;
        iss_r <= '0;
        col_r <= '0;
      end else begin
        if (run_r) begin
          iss_r <= iss_r + PAIR_W'(1);
          if (iss_r == PAIR_W'(N_PAIRS - 1)) run_r <= 1'b0;
        end
        if (pv_r && pcol_r) col_r <= col_r + COL_W'(1);
      end
    end
  end

  // Multiplier stage
  always_ff @(posedge clk) begin
    prod_r  <= {{LIMB_W{1'b0}}, op_a} * {{LIMB_W{1'b0}}, op_b};
    pcol_r  <= pr.col_end;
    plast_r <= (iss_r == PAIR_W'(N_PAIRS - 1));
  end

  // Column accumulator, limbs of columns 4..6 kept
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
    end else if (pv_r) begin
      if (pcol_r) begin
        acc_r <= sum >> LIMB_W;
        if (col_r[2]) limb_r[col_r[1:0]] <= sum[LIMB_W-1:0];
      end else begin
        acc_r <= sum;
      end
    end
  end

  assign done = done_r;
  assign hi   = {acc_r[LIMB_W-1:0], limb_r[2], limb_r[1], limb_r[0]};

endmodule

// ===== hdl/fixed_point_log2_64p128.sv =====
// ----------------------------------------------------------------------------
// fixed_point_log2_64p128: binary log of a 64.128 unsigned fixed-point value
// Normalizes the operand, then produces 128 fraction bits by repeated
// squaring on a shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one operand per transaction. in_tdata = {x_frac_lo, x_frac_hi,
//           x_int_part}. in_tready is high only while the block is idle.
//   out_* : one result per operand. out_tdata = {log_frac_lo, log_frac_hi,
//           log_int}, out_tuser = zero_input. Held until out_tready.
// Sequence:
//   Normalization tests one shift span per cycle, then hands over to the
//   squaring loop. Each fraction bit needs one squaring of 16 partial
//   products through the single multiplier plus pipeline drain, for all
//   128 bits; the finished result waits in the hold state until it loads
//   the output register. The next operand is taken only once the block is
//   idle again. A zero operand skips normalization and squaring and returns
//   a flagged all-zero result through the hold state and output register.
//   The squaring loop over the shared multiplier sets the rate.
// Reset: rst_n (synchronous, active low) returns the sequencer to idle and
//   drops out_tvalid; no clearing pass is needed.
// Stall: a result waiting on out_tready holds out_*; the block goes back to
//   idle once the result is in the output register, and a finished result
//   waits in its hold state until the output register frees up.
// ----------------------------------------------------------------------------
module fixed_point_log2_64p128 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [63:0] x_int_part, [127:64] x_frac_hi, [191:128] x_frac_lo
  input  logic [fpl2_pkg::X_W-1:0]          in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] log_int, [71:8] log_frac_hi, [135:72] log_frac_lo
  output logic [fpl2_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] zero_input
  output logic [fpl2_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import fpl2_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_NORM = 4'b0010,
    ST_SQR  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t                  st_r, st_nxt;
  logic [FRAC_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [X_FRAC_W-1:0]     frac_r, frac_nxt;
  logic [LOG_FRAC_W-1:0]   res_frac_r, res_frac_nxt;
  logic [LOG_INT_W-1:0]    res_int_r, res_int_nxt;
  logic                    res_zero_r, res_zero_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]  out_tdata_r;
  logic                    out_tuser_r;
  logic                    out_load;

  logic                    in_acc;
  logic                    in_zero;
  logic [X_W-1:0]          in_x;
  logic                    nm_start, nm_done;
  logic [LZ_W-1:0]         nm_lz;
  logic [X_FRAC_W-1:0]     nm_frac;
  logic                    sq_start, sq_done;
  logic [X_FRAC_W-1:0]     sq_hi;

  // Squaring step: value 1+F squares to 1 + 2F + hi(F*F)
  logic [X_FRAC_W+1:0]     upd_sum;
  logic [X_FRAC_W+2:0]     upd_tot;
  logic                    upd_bit;

  assign in_acc  = in_tvalid && in_tready;
  assign in_zero = (in_tdata == '0);

  // Operand as one value, integer word on top
  assign in_x = {in_tdata[WORD_W-1:0], in_tdata[2*WORD_W-1:WORD_W],
                 in_tdata[X_W-1:2*WORD_W]};

  assign upd_sum = {1'b0, frac_r, 1'b0} + {2'b00, sq_hi};
  assign upd_tot = {1'b0, upd_sum} + ((X_FRAC_W+3)'(1) << X_FRAC_W);
  assign upd_bit = |upd_sum[X_FRAC_W+1:X_FRAC_W];

  fpl2_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nm_start),
    .x     (in_x),
    .done  (nm_done),
    .lz    (nm_lz),
    .frac  (nm_frac)
  );

  fpl2_sqr u_sqr (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .f     (frac_r),
    .done  (sq_done),
    .hi    (sq_hi)
  );

  // Sequencer
  always_comb begin
    st_nxt       = st_r;
    cnt_nxt      = cnt_r;
    frac_nxt     = frac_r;
    res_frac_nxt = res_frac_r;
    res_int_nxt  = res_int_r;
    res_zero_nxt = res_zero_r;
    nm_start     = 1'b0;
    sq_start     = 1'b0;
    out_load     = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_frac_nxt = '0;
          res_int_nxt  = '0;
          res_zero_nxt = in_zero;
          if (in_zero) begin
            st_nxt = ST_HOLD;
          end else begin
            nm_start = 1'b1;
            st_nxt   = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (nm_done) begin
          frac_nxt    = nm_frac;
          res_int_nxt = LOG_INT_W'(X_INT_W - 1) - nm_lz;
          cnt_nxt     = '0;
          sq_start    = 1'b1;
          st_nxt      = ST_SQR;
        end
      end
      ST_SQR: begin
        if (sq_done) begin
          res_frac_nxt = {res_frac_r[LOG_FRAC_W-2:0], upd_bit};
          frac_nxt     = upd_bit ? upd_tot[X_FRAC_W:1] : upd_sum[X_FRAC_W-1:0];
          if (cnt_r == FRAC_CNT_W'(LOG_FRAC_W - 1)) begin
            st_nxt = ST_HOLD;
          end else begin
            cnt_nxt  = cnt_r + FRAC_CNT_W'(1);
            sq_start = 1'b1;
          end
        end
      end
      ST_HOLD: begin
        if (!out_tvalid_r || out_tready) begin
          out_load = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load)                       out_tvalid_nxt = 1'b1;
    else if (out_tvalid_r && out_tready) out_tvalid_nxt = 1'b0;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Working value and result
  always_ff @(posedge clk) begin
    frac_r     <= frac_nxt;
    res_frac_r <= res_frac_nxt;
    res_int_r  <= res_int_nxt;
    res_zero_r <= res_zero_nxt;
    if (out_load) begin
      out_tdata_r <= {res_frac_r[WORD_W-1:0], res_frac_r[LOG_FRAC_W-1:WORD_W], res_int_r};
      out_tuser_r <= res_zero_r;
    end
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== hdl/fpl2_chk.sv =====
// ----------------------------------------------------------------------------
// fpl2_chk: port-level checks for the fixed-point log2 block
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module fpl2_chk (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [fpl2_pkg::X_W-1:0]          in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [fpl2_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic [fpl2_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import fpl2_pkg::*;

  // Stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Zero flag comes with an all-zero log
  a_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("zero flag with nonzero log");

  // Nonzero operand keeps the block busy into normalization
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata != '0) |=>
      !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("ready too early after operand");

endmodule

bind fixed_point_log2_64p128 fpl2_chk u_fpl2_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== verif/tb_fixed_point_log2_64p128.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_point_log2_64p128: self-checking bench for the 64.128 log2 block
// Drives operands on the input stream and predicts results the table does not set
// with a bit-accurate model of normalize-then-square. Compares every result
// on the output stream, in order. A short directed table comes first, then
// random operands, some of log-uniform magnitude, under four idling phases.
// ----------------------------------------------------------------------------
module tb_fixed_point_log2_64p128;
  import fpl2_pkg::*;

  localparam int N_DIRECTED   = 20;
  localparam int N_RANDOM     = 1680;
  localparam int N_OPERANDS   = N_DIRECTED + N_RANDOM;
  // Cycle budget per operand covers a nonzero operand plus worst gaps and stalls, taken 3x
  localparam int CYCLE_LIMIT  = N_OPERANDS * 2600 * 3;
  localparam int DRAIN_CYCLES = 2400;
  localparam int MAX_REPORTS  = 10;

  // One log2 result, as split from out_tdata / out_tuser
  typedef struct packed {
    logic [LOG_INT_W-1:0] log_int;
    logic [63:0]          frac_hi;
    logic [63:0]          frac_lo;
    logic                 zero_flag;
  } log2_res_t;

  // One row of the directed table; the expected result is used when checked
  typedef struct packed {
    logic [63:0]          xi;
    logic [63:0]          xh;
    logic [63:0]          xl;
    logic                 checked;
    logic [LOG_INT_W-1:0] e_int;
    logic [63:0]          e_hi;
    logic [63:0]          e_lo;
    logic                 e_zero;
  } stim_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [X_W-1:0]         in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  log2_res_t pending_logs[$];
  int        mismatches    = 0;
  int        cycle_count   = 0;
  int        send_gap_pct  = 0;
  int        stall_pct     = 0;

  fixed_point_log2_64p128 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted log2 of a 64.128 operand {int, frac_hi, frac_lo}
  function automatic log2_res_t compute_log2(input logic [X_W-1:0] x);
    logic [X_W-1:0]     t;
    logic [2*X_W-1:0]   sq;
    logic [X_FRAC_W-1:0] frac;
    int                 shift;
    log2_res_t          r;
    r = '0;
    t = x;
    if (t == '0) begin
      r.zero_flag = 1'b1;
      return r;
    end
    shift = 0;
    frac  = '0;
    // normalize into [1,2); bits shifted out on the right are lost
    while (t[X_W-1:X_FRAC_W+1] != '0) begin
      shift++;
      t = t >> 1;
    end
    while (t[X_W-1:X_FRAC_W] == '0) begin
      shift--;
      t = t << 1;
    end
    // one fraction bit per square, square truncated to 128 fraction bits
    for (int b = X_FRAC_W - 1; b >= 0; b--) begin
      sq = {{X_W{1'b0}}, t} * {{X_W{1'b0}}, t};
      t  = sq[X_W+X_FRAC_W-1:X_FRAC_W];
      if (t[X_W-1:X_FRAC_W+1] != '0) begin
        frac[b] = 1'b1;
        t = t >> 1;
      end
    end
    r.log_int = shift[LOG_INT_W-1:0];
    r.frac_hi = frac[127:64];
    r.frac_lo = frac[63:0];
    return r;
  endfunction

  // Directed operands: extremes, exact powers of two, zero
  function automatic stim_row_t directed_row(input int k);
    stim_row_t r;
    r = '0;
    case (k)
      // zero operand: flagged, all fields zero
      0:  r = '{64'h0, 64'h0, 64'h0, 1'b1, 8'h00, 64'h0, 64'h0, 1'b1};
      // exact powers of two give a zero fraction
      1:  r = '{64'h1, 64'h0, 64'h0, 1'b1, 8'h00, 64'h0, 64'h0, 1'b0};
      2:  r = '{64'h2, 64'h0, 64'h0, 1'b1, 8'h01, 64'h0, 64'h0, 1'b0};
      3:  r = '{64'h8000_0000_0000_0000, 64'h0, 64'h0,
                1'b1, 8'h3F, 64'h0, 64'h0, 1'b0};
      4:  r = '{64'h0, 64'h0, 64'h1, 1'b1, 8'h80, 64'h0, 64'h0, 1'b0};
      5:  r = '{64'h0, 64'h8000_0000_0000_0000, 64'h0,
                1'b1, 8'hFF, 64'h0, 64'h0, 1'b0};
      6:  r = '{64'h0, 64'h0, 64'h8000_0000_0000_0000,
                1'b1, 8'hBF, 64'h0, 64'h0, 1'b0};
      7:  r = '{64'h0, 64'h1, 64'h0, 1'b1, 8'hC0, 64'h0, 64'h0, 1'b0};
      8:  r = '{64'h1_0000_0000, 64'h0, 64'h0, 1'b1, 8'h20, 64'h0, 64'h0, 1'b0};
      // the rows below up to the final zero go through the predictor
      9:  r = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 1'b0, 8'h0, 64'h0, 64'h0, 1'b0};
      10: r = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h0, 64'h0, 64'h0, 1'b0};
      11: r = '{64'h3, 64'h0, 64'h0, 1'b0, 8'h0, 64'h0, 64'h0, 1'b0};
      12: r = '{64'h1, 64'h8000_0000_0000_0000, 64'h0,
                1'b0, 8'h0, 64'h0, 64'h0, 1'b0};
      // just below two and just above one
      13: r = '{64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                1'b0, 8'h0, 64'h0, 64'h0, 1'b0};
      14: r = '{64'h1, 64'h0, 64'h1, 1'b0, 8'h0, 64'h0, 64'h0, 1'b0};
      15: r = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                1'b0, 8'h0, 64'h0, 64'h0, 1'b0};
      16: r = '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 8'h0, 64'h0, 64'h0, 1'b0};
      17: r = '{64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h0, 64'h0, 64'h0, 1'b0};
      18: r = '{64'h8000_0000_0000_0000, 64'h0, 64'h1,
                1'b0, 8'h0, 64'h0, 64'h0, 1'b0};
      // zero again, right after a nonzero operand
      default: r = '{64'h0, 64'h0, 64'h0, 1'b1, 8'h00, 64'h0, 64'h0, 1'b1};
    endcase
    return r;
  endfunction

  // Present one operand, wait for its transaction, then queue its result
  task automatic send_operand(input logic [X_W-1:0] v, input log2_res_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v[63:0], v[127:64], v[191:128]};
    do @(posedge clk); while (!in_tready);
    pending_logs.push_back(want);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    log2_res_t got;
    log2_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.log_int   = out_tdata[7:0];
      got.frac_hi   = out_tdata[71:8];
      got.frac_lo   = out_tdata[135:72];
      got.zero_flag = out_tuser[0];
      if (pending_logs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: int=%0d hi=%h lo=%h zero=%b",
                   $signed(got.log_int), got.frac_hi, got.frac_lo, got.zero_flag);
      end else begin
        want = pending_logs.pop_front();
        if (got.log_int !== want.log_int || got.frac_hi !== want.frac_hi ||
            got.frac_lo !== want.frac_lo || got.zero_flag !== want.zero_flag) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("log2 mismatch: expected int=%0d hi=%h lo=%h zero=%b",
                     $signed(want.log_int), want.frac_hi, want.frac_lo, want.zero_flag);
            $display("               actual   int=%0d hi=%h lo=%h zero=%b",
                     $signed(got.log_int), got.frac_hi, got.frac_lo, got.zero_flag);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus
  initial begin
    stim_row_t       row;
    log2_res_t       want;
    logic [X_W-1:0]  opv;
    logic [X_W-1:0]  mask;
    int              kind;
    int              pos;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed table, no idling
    for (int k = 0; k < N_DIRECTED; k++) begin
      row = directed_row(k);
      opv = {row.xi, row.xh, row.xl};
      if (row.checked)
        want = '{row.e_int, row.e_hi, row.e_lo, row.e_zero};
      else
        want = compute_log2(opv);
      send_operand(opv, want);
    end

    // random operands over four idling phases
    for (int n = 0; n < N_RANDOM; n++) begin
      case ((n * 4) / N_RANDOM)
        0: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
        1: begin
          send_gap_pct = 84;
          stall_pct    = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct    = 84;
        end
        default: begin
          send_gap_pct = 25;
          stall_pct    = 25;
        end
      endcase

      kind = $urandom_range(19);
      pos  = $urandom_range(X_W - 1);
      case (kind)
        0: opv = '0;
        1: opv = {{(X_W-1){1'b0}}, 1'b1} << pos;
        2: begin
          // neighbors of a power of two
          if (pos == 0) pos = 1;
          opv = {{(X_W-1){1'b0}}, 1'b1} << pos;
          if ($urandom_range(1) == 1) opv = opv + 1'b1;
          else                        opv = opv - 1'b1;
        end
        3, 4, 5: opv = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        14, 15, 16: begin
          // operands near one, integer part 0 or 1
          opv = {64'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom};
        end
        17, 18, 19: begin
          opv = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom} &
                {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom} &
                {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        default: begin
          // log-uniform magnitude: leading one at a random position
          mask = ~({X_W{1'b1}} << pos << 1);
          opv  = ({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom} & mask) |
                 ({{(X_W-1){1'b0}}, 1'b1} << pos);
        end
      endcase
      send_operand(opv, compute_log2(opv));
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    send_gap_pct = 0;
    stall_pct    = 0;

    while (pending_logs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/fpl2_pkg.sv
hdl/fpl2_norm.sv
hdl/fpl2_sqr.sv
hdl/fixed_point_log2_64p128.sv
hdl/fpl2_chk.sv
verif/tb_fixed_point_log2_64p128.sv
